>>> hw/rtl/rpol_pkg.sv
// Shared types and constants for the replica placement and owner lookup unit.
// No dependencies; imported by every module of the block but rpol_ram.
`default_nettype none

package rpol_pkg;

   localparam int MAX_CHUNKS = 1024;
   localparam int MAX_NODES  = 64;

   localparam int CHUNK_W    = 10;   // chunk_id field
   localparam int PICK_W     = 6;    // replica_pick field
   localparam int NODE_W     = 6;    // owner_node field
   localparam int MASK_W     = 64;   // owner_mask field
   localparam int CFG_W      = 7;    // node_count / replica_count
   localparam int CSR_IDX_W  = 1;

   localparam int CHUNK_AW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int DIV_STEP_W = $clog2(CHUNK_W + 1);

   localparam logic ACT_PLACE = 1'b0;
   localparam logic ACT_FIND  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLICA_COUNT = 1'b1;

   typedef struct packed {
      logic               done;
      logic [CHUNK_W-1:0] quot;
      logic [CFG_W-1:0]   rem;
   } div_res_type;

   typedef struct packed {
      logic              done;
      logic [MASK_W-1:0] mask;
   } place_res_type;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [NODE_W-1:0] node;
   } scan_res_type;

endpackage

`default_nettype wire

>>> hw/rtl/rpol_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module rpol_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                                         clock,
   input  wire logic                                         we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                             wdata,
   output logic      [WIDTH-1:0]                             rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rpol_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rpol_pkg.
`default_nettype none

module rpol_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rpol_pkg::CHUNK_W-1:0]  dividend,
   input  wire logic [rpol_pkg::CFG_W-1:0]    divisor,
   output rpol_pkg::div_res_type              res
);
   import rpol_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic [CHUNK_W-1:0]    dvd_ff, dvd_in;
   logic [CFG_W-1:0]      rem_ff, rem_in;
   logic [CFG_W-1:0]      dsr_ff, dsr_in;
   logic [CFG_W:0]        rem_sh;
   logic [CFG_W:0]        rem_sub;
   logic                  ge;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[CHUNK_W-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      ge      = rem_sh >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top bit drops out
         rem_in = ge ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];
         dvd_in = {dvd_ff[CHUNK_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_STEP_W'(CHUNK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign res.done = done_ff;
   assign res.quot = dvd_ff;
   assign res.rem  = rem_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rpol_place.sv
// Round-robin placement mask builder: chunk mod N, N div R, then one owner a cycle.
// Depends on rpol_pkg and rpol_div.
`default_nettype none

module rpol_place (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rpol_pkg::CHUNK_W-1:0]  chunk,
   input  wire logic [rpol_pkg::CFG_W-1:0]    node_cnt,
   input  wire logic [rpol_pkg::CFG_W-1:0]    repl_cnt,
   output rpol_pkg::place_res_type            res
);
   import rpol_pkg::*;

   localparam logic [1:0] P_IDLE   = 2'd0;
   localparam logic [1:0] P_BASE   = 2'd1;
   localparam logic [1:0] P_STRIDE = 2'd2;
   localparam logic [1:0] P_LOOP   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic              done_ff, done_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [NODE_W-1:0] owner_ff, owner_in;
   logic [CFG_W-1:0]  stride_ff, stride_in;
   logic [CFG_W-1:0]  k_ff, k_in;
   logic [CFG_W-1:0]  k_nxt;
   logic [CFG_W:0]    owner_sum;
   logic [CFG_W:0]    owner_wrap;
   logic [MASK_W-1:0] fill_mask;

   logic               div_start;
   logic [CHUNK_W-1:0] div_dividend;
   logic [CFG_W-1:0]   div_divisor;
   div_res_type        div_res;

   rpol_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .res      (div_res)
   );

   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         fill_mask[i] = CFG_W'(i) < node_cnt;
      end
      owner_sum  = {2'b00, owner_ff} + {1'b0, stride_ff};
      owner_wrap = (owner_sum >= {1'b0, node_cnt}) ? owner_sum - {1'b0, node_cnt}
                                                   : owner_sum;
      k_nxt        = k_ff + 1'b1;
      state_in     = state_ff;
      done_in      = 1'b0;
      mask_in      = mask_ff;
      owner_in     = owner_ff;
      stride_in    = stride_ff;
      k_in         = k_ff;
      div_start    = 1'b0;
      div_dividend = chunk;
      div_divisor  = node_cnt;
      unique case (state_ff)
         P_IDLE: begin
            if (start) begin
               priority if (node_cnt == '0) begin
                  mask_in = '0;
                  done_in = 1'b1;
               end else if (repl_cnt >= node_cnt) begin
                  mask_in = fill_mask;
                  done_in = 1'b1;
               end else if (repl_cnt == '0) begin
                  mask_in = '0;
                  done_in = 1'b1;
               end else begin
                  mask_in   = '0;
                  div_start = 1'b1;
                  state_in  = P_BASE;
               end
            end
         end
         P_BASE: begin
            div_dividend = CHUNK_W'(node_cnt);
            div_divisor  = repl_cnt;
            if (div_res.done) begin
               owner_in  = div_res.rem[NODE_W-1:0];
               div_start = 1'b1;
               state_in  = P_STRIDE;
            end
         end
         P_STRIDE: begin
            if (div_res.done) begin
               stride_in = div_res.quot[CFG_W-1:0];
               k_in      = '0;
               state_in  = P_LOOP;
            end
         end
         P_LOOP: begin
            mask_in  = mask_ff | (MASK_W'(1) << owner_ff);
            owner_in = owner_wrap[NODE_W-1:0];
            k_in     = k_nxt;
            if (k_nxt == repl_cnt) begin
               done_in  = 1'b1;
               state_in = P_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff   <= mask_in;
      owner_ff  <= owner_in;
      stride_ff <= stride_in;
      k_ff      <= k_in;
   end

   assign res.done = done_ff;
   assign res.mask = mask_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rpol_scan.sv
// Owner scan: walks the mask one node a cycle and picks the pick-th set bit.
// Depends on rpol_pkg.
`default_nettype none

module rpol_scan (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [rpol_pkg::MASK_W-1:0]  mask,
   input  wire logic [rpol_pkg::CFG_W-1:0]   node_cnt,
   input  wire logic [rpol_pkg::PICK_W-1:0]  pick,
   output rpol_pkg::scan_res_type            res
);
   import rpol_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MASK_W-1:0] bits_ff, bits_in;
   logic [CFG_W-1:0]  idx_ff, idx_in;
   logic [PICK_W-1:0] pick_ff, pick_in;
   logic              found_ff, found_in;
   logic [NODE_W-1:0] node_ff, node_in;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      bits_in  = bits_ff;
      idx_in   = idx_ff;
      pick_in  = pick_ff;
      found_in = found_ff;
      node_in  = node_ff;
      if (start) begin
         busy_in  = 1'b1;
         bits_in  = mask;
         idx_in   = '0;
         pick_in  = pick;
         found_in = 1'b0;
         node_in  = '0;
      end else if (busy_ff) begin
         if (idx_ff >= node_cnt) begin
            // ran past the last node in use: keep the last owner seen
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bits_in = bits_ff >> 1;
            idx_in  = idx_ff + 1'b1;
            if (bits_ff[0]) begin
               found_in = 1'b1;
               node_in  = idx_ff[NODE_W-1:0];
               if (pick_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  pick_in = pick_ff - 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      idx_ff   <= idx_in;
      pick_ff  <= pick_in;
      found_ff <= found_in;
      node_ff  <= node_in;
   end

   assign res.done  = done_ff;
   assign res.found = found_ff;
   assign res.node  = node_ff;

endmodule

`default_nettype wire

>>> hw/rtl/replica_placement_owner_lookup_unit.sv
// Top level of the replica placement and owner lookup unit.
// Depends on rpol_pkg, rpol_ram, rpol_place, rpol_scan.
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     tdata: chunk_id[9:0], replica_pick[15:10]
//                                       tuser: action (0 place, 1 find)
//   rsp_     out  rsp_tvalid/tready     tdata: owner_node[5:0], owner_mask[69:6], pad
//                                       tuser: chunk_missing
//   csr_     in   csr_valid/csr_ready   csr_index (0 node_count, 1 replica_count),
//                                       csr_data
//
// One item at a time, from acceptance until the result enters the output register. Place:
//   the all-nodes and empty cases skip the divider, otherwise two passes of the bit-serial
//   divider, then one owner per cycle. Find: table read, then one node per cycle,
//   stopping early on the picked owner.
// After reset the owner table is zeroed one entry a cycle, with req_tready low until
//   every entry is clear. CSR writes are taken at any time.
// The result sits in an output register; a stalled rsp_ side holds the next finished
//   item in the unit until the register frees.
`default_nettype none

module replica_placement_owner_lookup_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // chunk_id[9:0], replica_pick[15:10]
   input  wire logic        req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // owner_node[5:0], owner_mask[69:6], zero[71:70]
   output logic             rsp_tuser,   // chunk_missing
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rpol_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rpol_pkg::CFG_W-1:0]         csr_data
);
   import rpol_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_PLACE = 3'd2;
   localparam logic [2:0] S_FETCH = 3'd3;
   localparam logic [2:0] S_LOAD  = 3'd4;
   localparam logic [2:0] S_SCAN  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CHUNK_AW-1:0] clr_addr_ff, clr_addr_in;
   logic [CFG_W-1:0]    node_cnt_ff, node_cnt_in;
   logic [CFG_W-1:0]    repl_cnt_ff, repl_cnt_in;
   logic [CHUNK_W-1:0]  chunk_ff, chunk_in;
   logic [PICK_W-1:0]   pick_ff, pick_in;
   logic [NODE_W-1:0]   res_node_ff, res_node_in;
   logic [MASK_W-1:0]   res_mask_ff, res_mask_in;
   logic                res_miss_ff, res_miss_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]   rsp_node_ff, rsp_node_in;
   logic [MASK_W-1:0]   rsp_mask_ff, rsp_mask_in;
   logic                rsp_miss_ff, rsp_miss_in;

   logic [CHUNK_W-1:0]  req_chunk;
   logic [PICK_W-1:0]   req_pick;
   logic                req_accept;
   logic                req_chunk_ok;
   logic [CFG_W-1:0]    nodes_in_use;

   logic                ram_we;
   logic [CHUNK_AW-1:0] ram_addr;
   logic [MASK_W-1:0]   ram_wdata;
   logic [MASK_W-1:0]   ram_rdata;

   logic                place_start;
   place_res_type       place_res;
   logic                scan_start;
   scan_res_type        scan_res;
   logic                out_free;

   assign req_chunk    = req_tdata[CHUNK_W-1:0];
   assign req_pick     = req_tdata[CHUNK_W +: PICK_W];
   assign req_accept   = req_tvalid && req_tready;
   assign req_chunk_ok = 32'(req_chunk) < 32'(MAX_CHUNKS);
   // node count saturates at the node limit
   assign nodes_in_use = (node_cnt_ff > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES)
                                                          : node_cnt_ff;
   assign out_free     = !rsp_valid_ff || rsp_tready;

   rpol_ram #(
      .WIDTH (MASK_W),
      .DEPTH (MAX_CHUNKS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   rpol_place u_place (
      .clock    (clock),
      .reset    (reset),
      .start    (place_start),
      .chunk    (req_chunk),
      .node_cnt (nodes_in_use),
      .repl_cnt (repl_cnt_ff),
      .res      (place_res)
   );

   rpol_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .mask     (ram_rdata),
      .node_cnt (nodes_in_use),
      .pick     (pick_ff),
      .res      (scan_res)
   );

   // CSR writes
   always_comb begin
      node_cnt_in = node_cnt_ff;
      repl_cnt_in = repl_cnt_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NODE_COUNT:    node_cnt_in = csr_data;
            CSR_REPLICA_COUNT: repl_cnt_in = csr_data;
         endcase
      end
   end

   // main sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      chunk_in     = chunk_ff;
      pick_in      = pick_ff;
      res_node_in  = res_node_ff;
      res_mask_in  = res_mask_ff;
      res_miss_in  = res_miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_node_in  = rsp_node_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_miss_in  = rsp_miss_ff;
      ram_we       = 1'b0;
      ram_addr     = CHUNK_AW'(chunk_ff);
      ram_wdata    = place_res.mask;
      place_start  = 1'b0;
      scan_start   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_addr    = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CHUNK_AW'(MAX_CHUNKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               chunk_in    = req_chunk;
               pick_in     = req_pick;
               res_node_in = '0;
               res_mask_in = '0;
               res_miss_in = 1'b0;
               priority if (!req_chunk_ok) begin
                  // out-of-range chunk: place writes nothing, find reports missing
                  res_miss_in = (req_tuser == ACT_FIND);
                  state_in    = S_DONE;
               end else if (req_tuser == ACT_PLACE) begin
                  place_start = 1'b1;
                  state_in    = S_PLACE;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_PLACE: begin
            if (place_res.done) begin
               ram_we      = 1'b1;
               res_mask_in = place_res.mask;
               state_in    = S_DONE;
            end
         end
         S_FETCH: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            res_mask_in = ram_rdata;
            scan_start  = 1'b1;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            if (scan_res.done) begin
               res_node_in = scan_res.found ? scan_res.node : '0;
               res_miss_in = !scan_res.found;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = res_node_ff;
               rsp_mask_in  = res_mask_ff;
               rsp_miss_in  = res_miss_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         node_cnt_ff  <= CFG_W'(1);
         repl_cnt_ff  <= CFG_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         node_cnt_ff  <= node_cnt_in;
         repl_cnt_ff  <= repl_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chunk_ff    <= chunk_in;
      pick_ff     <= pick_in;
      res_node_ff <= res_node_in;
      res_mask_ff <= res_mask_in;
      res_miss_ff <= res_miss_in;
      rsp_node_ff <= rsp_node_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_miss_ff <= rsp_miss_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_mask_ff, rsp_node_ff};
   assign rsp_tuser  = rsp_miss_ff;

endmodule

`default_nettype wire
